// ----- hdl/assert_macros.svh -----
// Assertion macros used by the lane RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/ssgs_pkg.sv -----
// Shared types, constants and rounding helpers of the slew gain smoother.
`timescale 1ns / 1ps
package ssgs_pkg;

  localparam int unsigned ONE_Q23 = 8388608;
  localparam int unsigned ONE_Q24 = 16777216;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CHASE  = 2'd0,
    REG_RATIO  = 2'd1,
    REG_MAKEUP = 2'd2,
    REG_WET    = 2'd3
  } reg_idx_t;

  // settings seen by every lane; wet already limited to one
  typedef struct packed {
    logic [23:0] chase;
    logic [20:0] ratio;
    logic [23:0] makeup;
    logic [24:0] wet;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

// ----- hdl/ssgs_lane.sv -----
// One channel lane: cascaded slew gain stages, makeup gain and wet/dry mix.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssgs_lane import ssgs_pkg::*; #(
  parameter int STAGES = 5,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctrl_t          ctrl,
  input  cfg_t                cfg,
  input  logic signed [23:0]  dry,
  output lane_stat_t          stat,
  output logic signed [23:0]  result
);

  localparam int TB = SINE_TABLE_BITS;
  localparam int TLEN = 1 << TB;
  localparam int QLEN = TLEN / 4;
  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  // reciprocals of the Taylor divisors (2k)(2k+1), exact for dividends below 2^33
  localparam logic [63:0] RCP_6   = ((64'd1 << 41) + 64'd5) / 64'd6;
  localparam logic [63:0] RCP_20  = ((64'd1 << 41) + 64'd19) / 64'd20;
  localparam logic [63:0] RCP_42  = ((64'd1 << 41) + 64'd41) / 64'd42;
  localparam logic [63:0] RCP_72  = ((64'd1 << 41) + 64'd71) / 64'd72;
  localparam logic [63:0] RCP_110 = ((64'd1 << 41) + 64'd109) / 64'd110;
  localparam logic [63:0] RCP_156 = ((64'd1 << 41) + 64'd155) / 64'd156;

  typedef logic signed [24:0] sine_rom_t [TLEN];

  // first quadrant sine in Q2.23, from a Q2.30 Taylor series to x^13
  function automatic logic signed [24:0] quarter_sine(input logic [63:0] steps);
    logic [63:0] x, x2, t, rcp;
    logic [127:0] wide;
    logic signed [63:0] s;
    x = (HALF_PI_Q30 * steps) >> (TB - 2);
    x2 = (x * x) >> 30;
    t = x;
    s = signed'(x);
    for (int k = 1; k <= 6; k++) begin
      case (k)
        1: rcp = RCP_6;
        2: rcp = RCP_20;
        3: rcp = RCP_42;
        4: rcp = RCP_72;
        5: rcp = RCP_110;
        default: rcp = RCP_156;
      endcase
      // divide by (2k)(2k+1) through its reciprocal
      wide = 128'((t * x2) >> 30) * 128'(rcp);
      t = wide[104:41];
      if (k % 2 == 1) s = s - signed'(t);
      else s = s + signed'(t);
    end
    if (s < 0) s = 0;
    s = (s + 64'sd64) >>> 7;
    if (s > 64'sd8388608) s = 64'sd8388608;
    return s[24:0];
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    int quad, r, steps;
    logic signed [24:0] v;
    for (int i = 0; i < TLEN; i++) begin
      quad = i >> (TB - 2);
      r = i & (QLEN - 1);
      steps = (quad % 2 == 1) ? (QLEN - r) : r;
      v = quarter_sine(64'(steps));
      rom[i] = (quad >= 2) ? -v : v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ANGLE  = 9'b000000010,
    S_PHASE  = 9'b000000100,
    S_LOOK   = 9'b000001000,
    S_GAIN   = 9'b000010000,
    S_SCALE  = 9'b000100000,
    S_MAKEUP = 9'b001000000,
    S_WET    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [STG_W-1:0] stg_r;
  logic signed [23:0] prev_r [STAGES];
  logic [23:0] gain_r [STAGES];

  logic signed [23:0] dry_r, x_r;
  logic [29:0] angle_r;
  logic [TB-1:0] idx_r;
  logic signed [24:0] sine_r;
  logic [47:0] p1_r;
  logic [23:0] g_r;
  logic signed [26:0] y_r;
  logic signed [23:0] res_r;
  logic last_stg;

  // per-state datapath
  logic signed [24:0] d;
  logic [24:0] diff;
  logic [45:0] slew;
  logic [59:0] ph;
  logic [31:0] phase;
  logic [24:0] om;
  logic [48:0] gsum;
  logic [24:0] gn;
  logic signed [48:0] xg;
  logic signed [48:0] xm;
  logic signed [53:0] total;

  always_comb begin
    d = 25'(x_r) - 25'(prev_r[stg_r]);
    diff = d[24] ? 25'(-d) : 25'(d);
    slew = 46'(diff) * 46'(cfg.ratio);
    ph = 60'(angle_r) * 60'(INV_TWO_PI_Q32);
    phase = ph[55:24];
    om = 25'(ONE_Q23) - 25'(sine_r);
    gsum = 49'(p1_r) + 49'(om) * 49'(cfg.chase) + 49'(ONE_Q23);
    gn = gsum[48:24];
    if (gn > 25'(ONE_Q23)) gn = 25'(ONE_Q23);
    xg = 49'(x_r) * signed'(49'({1'b0, g_r}));
    xm = 49'(x_r) * signed'(49'({1'b0, cfg.makeup}));
    total = 54'(y_r) * signed'(54'(cfg.wet))
          + 54'(dry_r) * signed'(54'(25'(ONE_Q24) - cfg.wet));
  end

  assign last_stg = (stg_r == STG_W'(STAGES - 1));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (ctrl.start) state_nxt = S_ANGLE;
      S_ANGLE:  state_nxt = S_PHASE;
      S_PHASE:  state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_SCALE;
      S_SCALE:  state_nxt = last_stg ? S_MAKEUP : S_ANGLE;
      S_MAKEUP: state_nxt = S_WET;
      S_WET:    state_nxt = S_DONE;
      S_DONE:   if (ctrl.ack) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stg_r <= '0;
      for (int i = 0; i < STAGES; i++) begin
        prev_r[i] <= '0;
        gain_r[i] <= 24'(ONE_Q23);
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) stg_r <= '0;
      else if (state_r == S_SCALE && !last_stg) stg_r <= stg_r + 1'b1;
      if (state_r == S_GAIN) begin
        gain_r[stg_r] <= gn[23:0];
        prev_r[stg_r] <= x_r;
      end
    end
  end

  // payload registers; the mix of the made-up and the dry sample lands in res_r
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        dry_r <= dry;
        x_r <= dry;
      end
      S_ANGLE: angle_r <= slew[44:15];
      S_PHASE: idx_r <= phase[31 -: TB];
      S_LOOK: begin
        sine_r <= SINE_ROM[idx_r];
        p1_r <= 48'(gain_r[stg_r]) * 48'(25'(ONE_Q24) - 25'(cfg.chase));
      end
      S_GAIN: g_r <= gn[23:0];
      S_SCALE: x_r <= 24'(rnd(64'(xg), 23));
      S_MAKEUP: y_r <= 27'(rnd(64'(xm), 22));
      S_WET: res_r <= sat24(rnd(64'(total), 24));
      S_DONE: ;
      default: ;
    endcase
  end

  assign stat.done = (state_r == S_DONE);
  assign result = res_r;

  // checks
  `ASSERT_SAME(a_start_idle, ctrl.start, state_r == S_IDLE, "start while lane busy")
  `ASSERT_NEXT(a_done_hold, state_r == S_DONE && !ctrl.ack, state_r == S_DONE, "result dropped")
  `ASSERT_SAME(a_gain_max, state_r == S_SCALE, g_r <= 24'(ONE_Q23), "gain above one")

endmodule

// ----- hdl/ssgs_merge.sv -----
// Collects the lane results into the output word register.
`timescale 1ns / 1ps
module ssgs_merge import ssgs_pkg::*; #(
  parameter int LANES = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_stat_t         stat [LANES],
  input  logic signed [23:0] res [LANES],
  output logic               load,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata
);

  logic valid_r;
  logic [47:0] data_r;
  logic all_done;
  logic [23:0] right;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < LANES; i++) all_done = all_done & stat[i].done;
  end

  generate
    if (LANES > 1) begin : g_two
      assign right = res[LANES-1];
    end else begin : g_one
      assign right = '0;
    end
  endgenerate

  // take the word when the slot is free or being emptied
  assign load = all_done && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (load) valid_r <= 1'b1;
    else if (out_tready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= {right, res[0]};
  end

  assign out_tvalid = valid_r;
  assign out_tdata = data_r;

endmodule

// ----- hdl/stereo_slew_gain_smoother.sv -----
// Top level of the stereo slew gain smoother.
//  channel | dir | handshake          | word
//  in_     | in  | in_tvalid/tready   | left_sample, right_sample
//  out_    | out | out_tvalid/tready  | left_out, right_out
//  cfg_    | in  | cfg_we             | register index, data
// One lane per channel, two at most; each lane runs its stages one after another,
// each through the angle, phase, look-up, gain and scale states, then makeup, mix
// and hand-off; the next word is taken at best in the cycle out_tvalid rises.
// A new word is taken once the lanes handed the last one to the output register.
// Reset is synchronous, active low, and restores the stage state and the configuration registers.
// A stalled output holds its word; lanes wait in their done state meanwhile.
`timescale 1ns / 1ps
module stereo_slew_gain_smoother import ssgs_pkg::*; #(
  parameter int STAGES = 5,
  parameter int CHANNELS = 2,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // left_sample [23:0], right_sample [47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_out [23:0], right_out [47:24]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [24:0] cfg_wdata
);

  localparam int LANES = (CHANNELS < 2) ? CHANNELS : 2;

  logic [23:0] chase_r, makeup_r;
  logic [20:0] ratio_r;
  logic [24:0] wet_r;
  logic busy_r;
  logic load;
  cfg_t cfg;
  lane_ctrl_t ctrl;
  lane_stat_t stat [LANES];
  logic signed [23:0] res [LANES];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chase_r <= '0;
      ratio_r <= '0;
      makeup_r <= 24'd4194304;
      wet_r <= 25'(ONE_Q24);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CHASE:  chase_r <= cfg_wdata[23:0];
        REG_RATIO:  ratio_r <= cfg_wdata[20:0];
        REG_MAKEUP: makeup_r <= cfg_wdata[23:0];
        REG_WET:    wet_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.chase = chase_r;
  assign cfg.ratio = ratio_r;
  assign cfg.makeup = makeup_r;
  assign cfg.wet = (wet_r > 25'(ONE_Q24)) ? 25'(ONE_Q24) : wet_r;

  // one word in flight
  assign in_tready = !busy_r;
  assign ctrl.start = in_tvalid && in_tready;
  assign ctrl.ack = load;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (ctrl.start) busy_r <= 1'b1;
    else if (load) busy_r <= 1'b0;
  end

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      ssgs_lane #(
        .STAGES(STAGES),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
      ) u_lane (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(ctrl),
        .cfg(cfg),
        .dry(in_tdata[24*g +: 24]),
        .stat(stat[g]),
        .result(res[g])
      );
    end
  endgenerate

  ssgs_merge #(.LANES(LANES)) u_merge (
    .clk(clk),
    .rst_n(rst_n),
    .stat(stat),
    .res(res),
    .load(load),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

endmodule

// ----- sim/tb_stereo_slew_gain_smoother.sv -----
// Self-checking testbench of the stereo slew gain smoother with a built-in smoother model.
`timescale 1ns / 1ps
module tb_stereo_slew_gain_smoother import ssgs_pkg::*;;

  localparam int NSTG = 5;
  localparam int TBITS = 10;
  localparam int TLEN = 1 << TBITS;
  localparam int WDOG_LIMIT = 4000;
  localparam int N_RANDOM = 1450;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // left_sample [23:0], right_sample [47:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // left_out [23:0], right_out [47:24]
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [24:0] cfg_wdata;

  stereo_slew_gain_smoother dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // model state; the table holds +1.0 at the quarter turn, so it needs 25 bits
  logic signed [24:0] sine_lut [TLEN];
  logic [63:0] m_chase, m_ratio, m_makeup, m_wet;
  logic signed [23:0] prev_smp [2][NSTG];
  logic [23:0] stg_gain [2][NSTG];

  logic [47:0] frame_q [$];
  logic [47:0] expected_q [$];
  int errors;
  int idle_pct;
  int wdog;
  bit stim_done;

  function automatic longint rshift_near(longint v, int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int quarter_sin(int unsigned steps);
    longint unsigned x, x2, t;
    longint s;
    x = (64'd1686629713 * steps) >> (TBITS - 2);
    x2 = (x * x) >> 30;
    t = x;
    s = x;
    for (int k = 1; k <= 6; k++) begin
      t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2) s -= t; else s += t;
    end
    if (s < 0) s = 0;
    s = (s + 64) >> 7;
    if (s > ONE_Q23) s = ONE_Q23;
    return int'(s);
  endfunction

  task automatic model_reset();
    int q, quad, r, v;
    q = TLEN / 4;
    for (int i = 0; i < TLEN; i++) begin
      quad = i / q; r = i % q;
      v = quarter_sin((quad % 2) ? q - r : r);
      sine_lut[i] = 25'((quad >= 2) ? -v : v);
    end
    m_chase = '0; m_ratio = '0; m_makeup = 64'd4194304; m_wet = 64'(ONE_Q24);
    for (int c = 0; c < 2; c++)
      for (int s = 0; s < NSTG; s++) begin
        prev_smp[c][s] = '0;
        stg_gain[c][s] = 24'(ONE_Q23);
      end
  endtask

  function automatic longint smooth_stage(int c, int s, longint x);
    longint d;
    longint unsigned diff, ang, g, one_minus;
    logic [31:0] phase;
    d = x - longint'(prev_smp[c][s]);
    diff = (d < 0) ? -d : d;
    ang = (diff * m_ratio) >> 15;
    phase = 32'((ang * 64'd683565276) >> 24);
    one_minus = longint'(ONE_Q23) - longint'(sine_lut[phase[31 -: TBITS]]);
    g = stg_gain[c][s];
    g = (g * (ONE_Q24 - m_chase) + one_minus * m_chase + (64'd1 << 23)) >> 24;
    if (g > ONE_Q23) g = ONE_Q23;
    stg_gain[c][s] = g[23:0];
    prev_smp[c][s] = x[23:0];
    return rshift_near(x * longint'(g), 23);
  endfunction

  function automatic logic [47:0] smooth_frame(logic [47:0] frame);
    logic [47:0] res;
    longint unsigned wet;
    longint dry, y;
    wet = (m_wet > ONE_Q24) ? ONE_Q24 : m_wet;
    for (int c = 0; c < 2; c++) begin
      dry = longint'($signed(frame[c*24 +: 24]));
      y = dry;
      for (int s = 0; s < NSTG; s++) y = smooth_stage(c, s, y);
      y = rshift_near(y * longint'(m_makeup), 22);
      y = rshift_near(y * longint'(wet) + dry * (longint'(ONE_Q24) - longint'(wet)), 24);
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      res[c*24 +: 24] = y[23:0];
    end
    return res;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: expectation is formed at acceptance so config order stays right
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(smooth_frame(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (frame_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tdata <= frame_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor, output stall and watchdog
  always @(posedge clk) begin
    logic [47:0] exp_w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      wdog <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word %h", out_tdata);
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_tdata[23:0] !== exp_w[23:0]) begin
            $error("left_out expected %h actual %h", exp_w[23:0], out_tdata[23:0]);
            errors++;
          end
          if (out_tdata[47:24] !== exp_w[47:24]) begin
            $error("right_out expected %h actual %h", exp_w[47:24], out_tdata[47:24]);
            errors++;
          end
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("FAIL stereo_slew_gain_smoother");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [24:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHASE:  m_chase = val[23:0];
      REG_RATIO:  m_ratio = val[20:0];
      REG_MAKEUP: m_makeup = val[23:0];
      default:    m_wet = val;
    endcase
  endtask

  task automatic drain();
    while (frame_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_smp();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [23:0] l, r;
    for (int i = 0; i < n; i++) begin
      l = rand_smp();
      r = ($urandom_range(3) == 0) ? l : rand_smp();
      frame_q.push_back({r, l});
    end
    drain();
  endtask

  // stimulus
  initial begin
    errors = 0;
    idle_pct = 34;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes
    frame_q.push_back({24'h000000, 24'h000000});
    frame_q.push_back({24'h800000, 24'h7fffff});
    frame_q.push_back({24'h7fffff, 24'h800000});
    frame_q.push_back({24'hffffff, 24'h000001});
    drain();
    // strong smoothing, overdriven makeup, wet above one
    cfg_write(REG_CHASE, 25'd16777215);
    cfg_write(REG_RATIO, 25'd1572864);
    cfg_write(REG_MAKEUP, 25'h0ffffff);
    cfg_write(REG_WET, 25'h1ffffff);
    frame_q.push_back({24'h7fffff, 24'h800000});
    frame_q.push_back({24'h800000, 24'h7fffff});
    frame_q.push_back({24'h400000, 24'hc00000});
    frame_q.push_back({24'h000000, 24'h000000});
    frame_q.push_back({24'h7fffff, 24'h7fffff});
    drain();
    // fully dry, out-of-range ratio
    cfg_write(REG_WET, 25'd0);
    cfg_write(REG_RATIO, 25'h1fffff);
    frame_q.push_back({24'h800000, 24'h7fffff});
    frame_q.push_back({24'h123456, 24'hedcba9});
    drain();

    // random settings phases, one with no idling
    for (int p = 0; p < 6; p++) begin
      idle_pct = (p == 2) ? 0 : 34;
      cfg_write(REG_CHASE, (p == 0) ? 25'd0 : 25'($urandom_range(16777215)));
      cfg_write(REG_RATIO, (p == 1) ? 25'd1572864 : 25'($urandom_range(1572864)));
      cfg_write(REG_MAKEUP, (p == 3) ? 25'd10905190 : 25'($urandom_range(10905190)));
      cfg_write(REG_WET, (p == 4) ? 25'd16777216 : 25'($urandom_range(16777216)));
      random_phase(N_RANDOM / 6);
    end

    if (errors == 0) begin
      $display("PASS stereo_slew_gain_smoother");
    end else begin
      $display("FAIL stereo_slew_gain_smoother");
    end
    $finish;
  end

endmodule
